// ===== rtl/hmre_pkg.sv =====
// shared constants and transfer types for the hit/miss range error metrics block
package hmre_pkg;

    localparam int COUNT_BITS   = 20;
    localparam int COORD_BITS   = 24;
    localparam int N_AXES       = 3;
    localparam int Q_SHIFT      = 16;
    localparam int FRAC_BITS    = Q_SHIFT + 1;
    localparam int MEAN_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS     = COUNT_BITS + COORD_BITS + 1;
    localparam int SQ_BITS      = 2 * COORD_BITS + 2;
    localparam int ROOT_BITS    = COORD_BITS + 1;
    localparam int DEN_BITS     = COUNT_BITS + 1;
    localparam int DIV_NUM_BITS = (ERR_BITS > COUNT_BITS + Q_SHIFT) ?
                                  ERR_BITS : COUNT_BITS + Q_SHIFT;

    typedef struct packed {
        logic                         real_hit;
        logic                         sim_hit;
        logic signed [COORD_BITS-1:0] real_x;
        logic signed [COORD_BITS-1:0] real_y;
        logic signed [COORD_BITS-1:0] real_z;
        logic signed [COORD_BITS-1:0] sim_x;
        logic signed [COORD_BITS-1:0] sim_y;
        logic signed [COORD_BITS-1:0] sim_z;
        logic                         last_ray;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0] true_hit_count;
        logic [COUNT_BITS-1:0] false_hit_count;
        logic [COUNT_BITS-1:0] false_miss_count;
        logic [COUNT_BITS-1:0] true_miss_count;
        logic [MEAN_BITS-1:0]  mean_hit_error;
        logic                  mean_valid;
        logic [FRAC_BITS-1:0]  precision_frac;
        logic                  precision_valid;
        logic [FRAC_BITS-1:0]  recall_frac;
        logic                  recall_valid;
    } t_out_item;

endpackage

// ===== rtl/hmre_sqrt.sv =====
// bit-serial integer square root, two radicand bits per cycle
module hmre_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hmre_pkg::SQ_BITS-1:0]   i_radicand,
    output logic                           o_done,
    output logic [hmre_pkg::ROOT_BITS-1:0] o_root
);
    import hmre_pkg::*;

    localparam int STEPS    = SQ_BITS / 2;
    localparam int CNT_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int REM_BITS = ROOT_BITS + 2;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [SQ_BITS-1:0]   r_rad;
    logic [REM_BITS-1:0]  r_rem;
    logic [ROOT_BITS-1:0] r_root;

    logic [REM_BITS-1:0]  w_rem_sh;
    logic [REM_BITS-1:0]  w_trial;
    logic                 w_fit;

    assign w_rem_sh = {r_rem[REM_BITS-3:0], r_rad[SQ_BITS-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(STEPS - 1);
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[SQ_BITS-3:0], 2'b00};
                r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root <= {r_root[ROOT_BITS-2:0], w_fit};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/hmre_div.sv =====
// restoring shift-subtract divider, one quotient bit per cycle
module hmre_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [hmre_pkg::DIV_NUM_BITS-1:0] i_num,
    input  logic [hmre_pkg::DEN_BITS-1:0]     i_den,
    output logic                              o_done,
    output logic [hmre_pkg::DIV_NUM_BITS-1:0] o_quot
);
    import hmre_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_NUM_BITS);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_BITS-1:0]     r_cnt;
    logic [DIV_NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0]     r_den;
    logic [DEN_BITS-1:0]     r_rem;

    logic [DEN_BITS:0]       w_sh;
    logic [DEN_BITS:0]       w_sub;
    logic                    w_fit;

    assign w_sh  = {r_rem, r_num[DIV_NUM_BITS-1]};
    assign w_fit = (w_sh >= {1'b0, r_den});
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DIV_NUM_BITS - 1);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_fit ? w_sub[DEN_BITS-1:0] : w_sh[DEN_BITS-1:0];
                r_num <= {r_num[DIV_NUM_BITS-2:0], w_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== rtl/hit_miss_range_error_metrics.sv =====
// top level: ray classification, error accumulation and end-of-run metrics
//
//  channel | direction | payload    | transfer when
//  in      | input     | t_in_item  | i_in_valid & o_in_ready
//  out     | output    | t_out_item | o_out_valid & i_out_ready
//
//  a ray that is not a true hit is counted when it is taken
//  a true hit is taken, squared per axis on the shared multiplier, then the root is started,
//  the bit-serial square root runs and the error sum is updated
//  a last ray then adds three divisions, each skipped when its divisor is zero
//  the result sits in an output register; a new ray is taken while it waits
//  reset clears all counters, the error sum and the output valid, and opens the input
module hit_miss_range_error_metrics (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hmre_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hmre_pkg::t_out_item  o_out_data
);
    import hmre_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_DIV,
        S_DIVW,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        P_MEAN,
        P_PREC,
        P_REC
    } t_phase;

    t_state                  r_state;
    t_phase                  r_phase;
    t_in_item                r_item;
    logic [1:0]              r_k;
    logic [2*COORD_BITS-1:0] r_prod;
    logic [SQ_BITS-1:0]      r_acc;
    logic                    r_last;
    logic                    r_sq_start;
    logic                    r_div_start;
    logic [COUNT_BITS-1:0]   r_th;
    logic [COUNT_BITS-1:0]   r_fh;
    logic [COUNT_BITS-1:0]   r_fm;
    logic [COUNT_BITS-1:0]   r_tm;
    logic [ERR_BITS-1:0]     r_err;
    logic [MEAN_BITS-1:0]    r_mean;
    logic                    r_mean_v;
    logic [FRAC_BITS-1:0]    r_prec;
    logic                    r_prec_v;
    logic [FRAC_BITS-1:0]    r_rec;
    logic                    r_rec_v;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic signed [COORD_BITS-1:0] w_a;
    logic signed [COORD_BITS-1:0] w_b;
    logic signed [COORD_BITS:0]   w_diff;
    logic [COORD_BITS:0]          w_mag;
    logic [COORD_BITS-1:0]        w_abs;
    logic [2*COORD_BITS-1:0]      w_sq;
    logic                         w_sq_done;
    logic [ROOT_BITS-1:0]         w_root;
    logic [ERR_BITS:0]            w_err_sum;
    logic [DIV_NUM_BITS-1:0]      w_num;
    logic [DEN_BITS-1:0]          w_den;
    logic                         w_div_done;
    logic [DIV_NUM_BITS-1:0]      w_quot;
    logic                         w_accept;
    logic                         w_true_hit;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_true_hit = i_in_data.real_hit && i_in_data.sim_hit;

    // coordinate pair for the current axis
    always_comb begin
        case (r_k)
            2'd0:    begin w_a = r_item.real_x; w_b = r_item.sim_x; end
            2'd1:    begin w_a = r_item.real_y; w_b = r_item.sim_y; end
            default: begin w_a = r_item.real_z; w_b = r_item.sim_z; end
        endcase
    end

    assign w_diff = {w_a[COORD_BITS-1], w_a} - {w_b[COORD_BITS-1], w_b};
    assign w_mag  = w_diff[COORD_BITS] ? (~w_diff + 1'b1) : w_diff;
    assign w_abs  = w_mag[COORD_BITS-1:0];
    assign w_sq   = w_abs * w_abs;

    assign w_err_sum = {1'b0, r_err} + (ERR_BITS + 1)'(w_root);

    // operands of the shared divider
    always_comb begin
        unique case (r_phase)
            P_MEAN: begin
                w_num = DIV_NUM_BITS'(r_err);
                w_den = {1'b0, r_th};
            end
            P_PREC: begin
                w_num = DIV_NUM_BITS'({r_th, {Q_SHIFT{1'b0}}});
                w_den = {1'b0, r_th} + {1'b0, r_fh};
            end
            P_REC: begin
                w_num = DIV_NUM_BITS'({r_th, {Q_SHIFT{1'b0}}});
                w_den = {1'b0, r_th} + {1'b0, r_fm};
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    hmre_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_start),
        .i_radicand (r_acc),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    hmre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_MEAN;
            r_k         <= '0;
            r_last      <= 1'b0;
            r_sq_start  <= 1'b0;
            r_div_start <= 1'b0;
            r_th        <= '0;
            r_fh        <= '0;
            r_fm        <= '0;
            r_tm        <= '0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sq_start  <= 1'b0;
            r_div_start <= 1'b0;
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item <= i_in_data;
                        r_last <= i_in_data.last_ray;
                        if (w_true_hit) begin
                            if (r_th != '1) r_th <= r_th + 1'b1;
                            r_k     <= '0;
                            r_acc   <= '0;
                            r_state <= S_SQ;
                        end else begin
                            if (i_in_data.sim_hit) begin
                                if (r_fh != '1) r_fh <= r_fh + 1'b1;
                            end else if (i_in_data.real_hit) begin
                                if (r_fm != '1) r_fm <= r_fm + 1'b1;
                            end else begin
                                if (r_tm != '1) r_tm <= r_tm + 1'b1;
                            end
                            if (i_in_data.last_ray) begin
                                r_phase <= P_MEAN;
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_SQ: begin
                    r_prod <= w_sq;
                    if (r_k != 2'd0) begin
                        r_acc <= r_acc + SQ_BITS'(r_prod);
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'(N_AXES)) begin
                        r_sq_start <= 1'b1;
                        r_state    <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_sq_done) begin
                        r_err <= w_err_sum[ERR_BITS] ? '1 : w_err_sum[ERR_BITS-1:0];
                        if (r_last) begin
                            r_phase <= P_MEAN;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_den == '0) begin
                        unique case (r_phase)
                            P_MEAN: begin r_mean <= '0; r_mean_v <= 1'b0; end
                            P_PREC: begin r_prec <= '0; r_prec_v <= 1'b0; end
                            default: begin r_rec <= '0; r_rec_v <= 1'b0; end
                        endcase
                        if (r_phase == P_REC) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_phase <= t_phase'(r_phase + 1'b1);
                        end
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        unique case (r_phase)
                            P_MEAN: begin
                                r_mean   <= (|w_quot[DIV_NUM_BITS-1:MEAN_BITS]) ?
                                            '1 : w_quot[MEAN_BITS-1:0];
                                r_mean_v <= 1'b1;
                            end
                            P_PREC: begin
                                r_prec   <= w_quot[FRAC_BITS-1:0];
                                r_prec_v <= 1'b1;
                            end
                            default: begin
                                r_rec   <= w_quot[FRAC_BITS-1:0];
                                r_rec_v <= 1'b1;
                            end
                        endcase
                        if (r_phase == P_REC) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_phase <= t_phase'(r_phase + 1'b1);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid                <= 1'b1;
                        r_out.true_hit_count       <= r_th;
                        r_out.false_hit_count      <= r_fh;
                        r_out.false_miss_count     <= r_fm;
                        r_out.true_miss_count      <= r_tm;
                        r_out.mean_hit_error       <= r_mean;
                        r_out.mean_valid           <= r_mean_v;
                        r_out.precision_frac       <= r_prec;
                        r_out.precision_valid      <= r_prec_v;
                        r_out.recall_frac          <= r_rec;
                        r_out.recall_valid         <= r_rec_v;
                        r_th                       <= '0;
                        r_fh                       <= '0;
                        r_fm                       <= '0;
                        r_tm                       <= '0;
                        r_err                      <= '0;
                        r_state                    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/hmre_checker.sv =====
// port-level assertions for the hit/miss range error metrics block
module hmre_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input hmre_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input hmre_pkg::t_out_item o_out_data
);
    import hmre_pkg::*;

    localparam logic [FRAC_BITS-1:0] Q_ONE = FRAC_BITS'(1) << Q_SHIFT;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // only a last ray can raise a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.last_ray && !o_out_valid
        |=> !o_out_valid)
        else $error("result without a last ray");

    // the end-of-run divisions keep the input closed
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last_ray |=> !o_in_ready)
        else $error("input open straight after a last ray");

    // mean flag follows the true hit count
    a_mean_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.mean_valid == (o_out_data.true_hit_count != '0))
                     && (o_out_data.mean_valid || o_out_data.mean_hit_error == '0))
        else $error("mean valid flag inconsistent");

    // fractions never exceed one
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.precision_frac <= Q_ONE
                     && o_out_data.recall_frac <= Q_ONE)
        else $error("fraction above one");

endmodule

bind hit_miss_range_error_metrics hmre_checker u_hmre_checker (.*);
